// ===== design/prs_pkg.sv =====
// Shared constants for the parity stripe reassembler.
`default_nettype none
package prs_pkg;

  localparam int PART_COUNT_DEFAULT = 6;
  localparam int SECTOR_BYTES       = 16;
  localparam int HALVES             = 2;
  localparam int WORD_W             = 64;
  localparam int WORD_BYTES         = WORD_W / 8;
  localparam int PART_W             = 3;
  localparam int LINE_BYTES_W       = 7;
  localparam int COUNT_W            = 4;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic [PART_W-1:0] NO_PART_MISSING = 3'd6;

endpackage
`default_nettype wire

// ===== design/parity_stripe_reassembler.sv =====
// Top level of the parity stripe reassembler.
`default_nettype none
// The block takes a stripe line as one 64-bit word per transfer, tagged with
// its part and half, and keeps the latest word of every part and half in a
// line store. Part 0 is XOR parity and the rest are data. When the final
// word of a line (last part, half 1) is taken, the data parts are rebuilt
// where needed (the part named by missing_part becomes the XOR of all other
// parts) and the whole line goes as one job into a two-entry queue. The back
// end then sends the line out eight bytes per transfer, in part order,
// trimmed to line_bytes, capped at the data bytes of a line, with the bytes
// past byte_count forced to zero and line_end set on the last word. A line
// of zero length sends nothing. Input takes one transfer per cycle while
// in_stall is low; in_stall rises only while both queue entries hold lines
// whose last word has not yet gone into the output register. Output runs at
// one word per cycle while a line is queued and out_stall is low; the first
// word of a line passes through the queue and then the output register.
// missing_part is written through the cfg channel, which is always ready,
// and should only change while no line is in flight. Part indexes at or
// beyond the part count are ignored.
module parity_stripe_reassembler
  import prs_pkg::*;
#(
  parameter int PART_COUNT = PART_COUNT_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [PART_W-1:0]       cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [WORD_W-1:0]       data_word,
  input  wire logic [PART_W-1:0]       part_index,
  input  wire logic                    half_index,
  input  wire logic [LINE_BYTES_W-1:0] line_bytes,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [WORD_W-1:0]            out_word,
  output logic [COUNT_W-1:0]           byte_count,
  output logic                         line_end
);

  localparam int DATA_WORDS      = (PART_COUNT - 1) * HALVES;
  localparam int LINE_DATA_BYTES = (PART_COUNT - 1) * SECTOR_BYTES;
  localparam int LB_W            = $clog2(LINE_DATA_BYTES + 1);
  localparam int JOB_W           = LB_W + DATA_WORDS * WORD_W;

  logic [PART_W-1:0] missing_part;
  logic              accept;
  logic              job_push;
  logic [JOB_W-1:0]  job_in;
  logic [JOB_W-1:0]  job_head;
  logic              job_pop;
  logic              queue_full;
  logic              queue_has_job;

  // The configuration register is a plain write port with no back-pressure.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      missing_part <= NO_PART_MISSING;
    end else if (cfg_valid && cfg_ready) begin
      missing_part <= cfg_data;
    end
  end

  // Stalling on a full queue keeps a finished line from being dropped.
  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;

  prs_front #(
    .PART_COUNT(PART_COUNT)
  ) u_front (
    .clk         (clk),
    .accept      (accept),
    .data_word   (data_word),
    .part_index  (part_index),
    .half_index  (half_index),
    .line_bytes  (line_bytes),
    .missing_part(missing_part),
    .job_push    (job_push),
    .job_data    (job_in)
  );

  prs_queue #(
    .WIDTH(JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_data(job_in),
    .pop      (job_pop),
    .full     (queue_full),
    .not_empty(queue_has_job),
    .head_data(job_head)
  );

  prs_back #(
    .PART_COUNT(PART_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (queue_has_job),
    .job_data  (job_head),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .byte_count(byte_count),
    .line_end  (line_end)
  );

endmodule
`default_nettype wire

// ===== design/prs_front.sv =====
// Front end: line store, parity rebuild and line job assembly.
`default_nettype none
module prs_front
  import prs_pkg::*;
#(
  parameter int PART_COUNT = PART_COUNT_DEFAULT,
  localparam int STORE_DEPTH = PART_COUNT * HALVES,
  localparam int DATA_WORDS = (PART_COUNT - 1) * HALVES,
  localparam int LINE_DATA_BYTES = (PART_COUNT - 1) * SECTOR_BYTES,
  localparam int LB_W = $clog2(LINE_DATA_BYTES + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         accept,
  input  wire logic [WORD_W-1:0]            data_word,
  input  wire logic [PART_W-1:0]            part_index,
  input  wire logic                         half_index,
  input  wire logic [LINE_BYTES_W-1:0]      line_bytes,
  input  wire logic [PART_W-1:0]            missing_part,
  output logic                              job_push,
  output logic [LB_W+DATA_WORDS*WORD_W-1:0] job_data
);

  localparam int SIDX_W = $clog2(STORE_DEPTH);

  logic [WORD_W-1:0] line_store [STORE_DEPTH];
  logic [WORD_W-1:0] store_eff  [STORE_DEPTH];
  logic [WORD_W-1:0] rebuilt    [HALVES];
  logic [SIDX_W-1:0] widx;
  logic              part_ok;
  logic              final_word;
  logic [LB_W-1:0]   nbytes;

  assign part_ok    = 32'(part_index) < PART_COUNT;
  assign final_word = (32'(part_index) == PART_COUNT - 1) && half_index;
  assign widx       = SIDX_W'({part_index, half_index});

  always_ff @(posedge clk) begin
    if (accept && part_ok) begin
      line_store[widx] <= data_word;
    end
  end

  // The word arriving now is forwarded so the final word takes part.
  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      store_eff[i] = (accept && part_ok && widx == SIDX_W'(i)) ? data_word : line_store[i];
    end
  end

  always_comb begin
    for (int h = 0; h < HALVES; h++) begin
      rebuilt[h] = '0;
      for (int p = 0; p < PART_COUNT; p++) begin
        if (p != 32'(missing_part)) begin
          rebuilt[h] = rebuilt[h] ^ store_eff[p * HALVES + h];
        end
      end
    end
  end

  assign nbytes = (32'(line_bytes) > LINE_DATA_BYTES) ? LB_W'(LINE_DATA_BYTES)
                                                      : LB_W'(line_bytes);

  always_comb begin
    job_data[DATA_WORDS*WORD_W +: LB_W] = nbytes;
    for (int p = 1; p < PART_COUNT; p++) begin
      for (int h = 0; h < HALVES; h++) begin
        job_data[((p - 1) * HALVES + h) * WORD_W +: WORD_W] =
          (p == 32'(missing_part)) ? rebuilt[h] : store_eff[p * HALVES + h];
      end
    end
  end

  // A line of zero length produces nothing and is not queued.
  assign job_push = accept && final_word && (line_bytes != '0);

endmodule
`default_nettype wire

// ===== design/prs_queue.sv =====
// Short queue of complete line jobs between the front and back ends.
`default_nettype none
module prs_queue
  import prs_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full      = fill == CNT_W'(DEPTH);
  assign not_empty = fill != '0;
  assign head_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/prs_back.sv =====
// Back end: walks a line job and emits its words through an output register.
`default_nettype none
module prs_back
  import prs_pkg::*;
#(
  parameter int PART_COUNT = PART_COUNT_DEFAULT,
  localparam int DATA_WORDS = (PART_COUNT - 1) * HALVES,
  localparam int LINE_DATA_BYTES = (PART_COUNT - 1) * SECTOR_BYTES,
  localparam int LB_W = $clog2(LINE_DATA_BYTES + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         job_valid,
  input  wire logic [LB_W+DATA_WORDS*WORD_W-1:0] job_data,
  output logic                              job_pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [WORD_W-1:0]                 out_word,
  output logic [COUNT_W-1:0]                byte_count,
  output logic                              line_end
);

  localparam int WI_W = $clog2(DATA_WORDS);

  logic [WI_W-1:0]    emit_index;
  logic [LB_W-1:0]    remaining;
  logic [LB_W-1:0]    cur_rem;
  logic [COUNT_W-1:0] take;
  logic [WORD_W-1:0]  sel_word;
  logic [WORD_W-1:0]  masked;
  logic               last_word;
  logic               load;

  // At the first word of a job the length comes straight from the job.
  assign cur_rem   = (emit_index == '0) ? job_data[DATA_WORDS*WORD_W +: LB_W] : remaining;
  assign last_word = cur_rem <= LB_W'(WORD_BYTES);
  assign take      = last_word ? COUNT_W'(cur_rem) : COUNT_W'(WORD_BYTES);
  assign sel_word  = job_data[emit_index * WORD_W +: WORD_W];
  assign load      = job_valid && (!out_valid || !out_stall);
  assign job_pop   = load && last_word;

  always_comb begin
    for (int k = 0; k < WORD_BYTES; k++) begin
      masked[k*8 +: 8] = (COUNT_W'(k) < take) ? sel_word[k*8 +: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      emit_index <= '0;
    end else begin
      if (load) begin
        out_valid  <= 1'b1;
        emit_index <= last_word ? '0 : emit_index + 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      remaining  <= cur_rem - LB_W'(WORD_BYTES);
      out_word   <= masked;
      byte_count <= take;
      line_end   <= last_word;
    end
  end

endmodule
`default_nettype wire
